[hdl/necir_pkg.sv]
// necir_pkg: shared types and constants of the nec infrared frame decoder
// decode phase enum, configuration register indexes and reset values, state structs
// no dependencies
package necir_pkg;

	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int IV_W      = 8;
	localparam int BYTE_W    = 8;
	localparam int WORD_W    = 32;
	localparam int BITPOS_W  = 5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_MIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_MAX     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_MIN       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_MAX       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESHOLD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_OVF   = 3'd5;

	// configuration reset values
	localparam logic [CFG_W-1:0] RST_START_MIN     = 8'h38;
	localparam logic [CFG_W-1:0] RST_START_MAX     = 8'h48;
	localparam logic [CFG_W-1:0] RST_BIT_MIN       = 8'h04;
	localparam logic [CFG_W-1:0] RST_BIT_MAX       = 8'h0F;
	localparam logic [CFG_W-1:0] RST_ONE_THRESHOLD = 8'h08;
	localparam logic [CFG_W-1:0] RST_TIMEOUT_OVF   = 8'h01 + 8'h01;

	// event codes
	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [BITPOS_W-1:0] LAST_BIT = 5'd31;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_START,
		PH_DATA
	} phase_t;

	typedef struct packed {
		logic [CFG_W-1:0] start_min;
		logic [CFG_W-1:0] start_max;
		logic [CFG_W-1:0] bit_min;
		logic [CFG_W-1:0] bit_max;
		logic [CFG_W-1:0] one_threshold;
		logic [CFG_W-1:0] timeout_overflows;
	} cfg_t;

	typedef struct packed {
		phase_t              phase;
		logic [BITPOS_W-1:0] bit_position;
		logic [WORD_W-1:0]   frame_word;
		logic                timer_running;
		logic [CFG_W-1:0]    overflows_left;
	} dec_state_t;

endpackage

[hdl/necir_in_if.sv]
// necir_in_if: event channel of the nec infrared frame decoder
// carries valid, ready, the event code and the measured interval; uses necir_pkg
interface necir_in_if;
	import necir_pkg::*;

	logic            valid;
	logic            ready;
	logic            cmd;
	logic [IV_W-1:0] interval;

	modport source (output valid, output cmd, output interval, input ready);
	modport sink (input valid, input cmd, input interval, output ready);
endinterface

[hdl/necir_out_if.sv]
// necir_out_if: result channel of the nec infrared frame decoder
// carries valid, ready, the frame bytes and status flags; uses necir_pkg
interface necir_out_if;
	import necir_pkg::*;

	logic              valid;
	logic              ready;
	logic              frame_done;
	logic [BYTE_W-1:0] address_low;
	logic [BYTE_W-1:0] address_high;
	logic [BYTE_W-1:0] command;
	logic [BYTE_W-1:0] command_inverse;
	logic              receiving;

	modport source (
		output valid, output frame_done, output address_low, output address_high,
		output command, output command_inverse, output receiving, input ready
	);
	modport sink (
		input valid, input frame_done, input address_low, input address_high,
		input command, input command_inverse, input receiving, output ready
	);
endinterface

[hdl/necir_cfg_regs.sv]
// necir_cfg_regs: configuration register file of the nec infrared frame decoder
// six 8-bit registers written through a plain write port; uses necir_pkg
module necir_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [necir_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [necir_pkg::CFG_W-1:0]     cfg_wdata,
	output necir_pkg::cfg_t                 cfg
);
	import necir_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_min         <= RST_START_MIN;
			cfg_q.start_max         <= RST_START_MAX;
			cfg_q.bit_min           <= RST_BIT_MIN;
			cfg_q.bit_max           <= RST_BIT_MAX;
			cfg_q.one_threshold     <= RST_ONE_THRESHOLD;
			cfg_q.timeout_overflows <= RST_TIMEOUT_OVF;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_MIN:     cfg_q.start_min         <= cfg_wdata;
				CFG_START_MAX:     cfg_q.start_max         <= cfg_wdata;
				CFG_BIT_MIN:       cfg_q.bit_min           <= cfg_wdata;
				CFG_BIT_MAX:       cfg_q.bit_max           <= cfg_wdata;
				CFG_ONE_THRESHOLD: cfg_q.one_threshold     <= cfg_wdata;
				CFG_TIMEOUT_OVF:   cfg_q.timeout_overflows <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

[hdl/necir_step.sv]
// necir_step: next-state logic of the nec infrared frame decoder for one event
// compares the interval with the configured bounds and updates the frame; uses necir_pkg
module necir_step (
	input  necir_pkg::cfg_t             cfg,
	input  necir_pkg::dec_state_t       cur,
	input  logic                        cmd,
	input  logic [necir_pkg::IV_W-1:0]  interval,
	output necir_pkg::dec_state_t       nxt,
	output logic                        done
);
	import necir_pkg::*;

	logic                 start_ok;
	logic                 bit_bad;
	logic                 bit_one;
	logic [CFG_W-1:0]     ovf_dec;
	logic [WORD_W-1:0]    bit_mask;

	// interval classification
	assign start_ok = (interval > cfg.start_min) && (interval < cfg.start_max);
	assign bit_bad  = (interval > cfg.bit_max) || (interval < cfg.bit_min);
	assign bit_one  = interval > cfg.one_threshold;
	assign ovf_dec  = cur.overflows_left - 1'b1;
	assign bit_mask = WORD_W'(1) << cur.bit_position;

	// state update
	always_comb begin
		nxt  = cur;
		done = 1'b0;
		if (cmd == CMD_TICK) begin
			if (cur.timer_running) begin
				nxt.overflows_left = ovf_dec;
				if (ovf_dec == '0) begin
					nxt.phase         = PH_IDLE;
					nxt.timer_running = 1'b0;
				end
			end
		end else begin
			case (cur.phase)
				PH_START: begin
					if (start_ok) begin
						nxt.frame_word   = '0;
						nxt.bit_position = '0;
						nxt.phase        = PH_DATA;
					end else begin
						nxt.phase = PH_IDLE;
					end
				end
				PH_DATA: begin
					if (bit_bad) begin
						nxt.phase = PH_IDLE;
					end else begin
						if (bit_one) begin
							nxt.frame_word = cur.frame_word | bit_mask;
						end
						if (cur.bit_position == LAST_BIT) begin
							nxt.bit_position = '0;
							nxt.phase        = PH_IDLE;
							done             = 1'b1;
						end else begin
							nxt.bit_position = cur.bit_position + 1'b1;
						end
					end
				end
				default: begin
					nxt.timer_running  = 1'b1;
					nxt.overflows_left = cfg.timeout_overflows;
					nxt.phase          = PH_START;
				end
			endcase
		end
	end
endmodule

[hdl/nec_ir_frame_decoder_core.sv]
// nec_ir_frame_decoder_core: nec infrared frame decoder, top level
// an accepted event passes the input register, then its result the result register
// throughput: one event per cycle unless a result is held; the state register loops via necir_step
// a waiting result holds both stages, one more event is taken only while the input stage is empty
// reset: phase idle, timer stopped, frame word and counters zero, configuration at defaults
// uses necir_pkg, necir_in_if, necir_out_if, necir_cfg_regs and necir_step
module nec_ir_frame_decoder_core #(
	parameter int COUNTER_WIDTH = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	necir_in_if.sink                        events,
	necir_out_if.source                     frames,
	input  logic                            cfg_we,
	input  logic [necir_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [necir_pkg::CFG_W-1:0]     cfg_wdata
);
	import necir_pkg::*;

	// interval bits that the counter actually delivers
	localparam int            TW      = (COUNTER_WIDTH < IV_W) ? COUNTER_WIDTH : IV_W;
	localparam logic [IV_W-1:0] IV_MASK = IV_W'((1 << TW) - 1);

	cfg_t             cfg;
	dec_state_t       state_q;
	dec_state_t       state_nxt;
	logic             done_nxt;
	logic             advance;

	logic             valid_s1;
	logic             cmd_s1;
	logic [IV_W-1:0]  interval_s1;

	logic             valid_s2;
	logic             done_s2;
	logic [WORD_W-1:0] word_s2;
	logic             receiving_s2;

	necir_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	necir_step u_step (
		.cfg      (cfg),
		.cur      (state_q),
		.cmd      (cmd_s1),
		.interval (interval_s1),
		.nxt      (state_nxt),
		.done     (done_nxt)
	);

	// pipeline moves when the result slot is free or being taken
	assign advance      = !valid_s2 || frames.ready;
	assign events.ready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (events.ready) begin
			valid_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (events.ready && events.valid) begin
			cmd_s1      <= events.cmd;
			interval_s1 <= events.interval & IV_MASK;
		end
	end

	// decoder state, updated once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase          <= PH_IDLE;
			state_q.bit_position   <= '0;
			state_q.frame_word     <= '0;
			state_q.timer_running  <= 1'b0;
			state_q.overflows_left <= '0;
		end else if (advance && valid_s1) begin
			state_q <= state_nxt;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			done_s2      <= done_nxt;
			word_s2      <= state_nxt.frame_word;
			receiving_s2 <= (state_nxt.phase != PH_IDLE);
		end
	end

	assign frames.valid           = valid_s2;
	assign frames.frame_done      = done_s2;
	assign frames.address_low     = word_s2[BYTE_W-1:0];
	assign frames.address_high    = word_s2[2*BYTE_W-1:BYTE_W];
	assign frames.command         = word_s2[3*BYTE_W-1:2*BYTE_W];
	assign frames.command_inverse = word_s2[4*BYTE_W-1:3*BYTE_W];
	assign frames.receiving       = receiving_s2;
endmodule
